[design/assert_macros.svh]
// Assertion helpers; they compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: lbl");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition: lbl");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

[design/gtor_pkg.sv]
package gtor_pkg;

  localparam int unsigned FRAME_WIDTH     = 320;
  localparam int unsigned BYTES_PER_PIXEL = 2;
  localparam int unsigned GLYPH_COLS      = 5;
  localparam int unsigned GLYPH_ROWS      = 7;
  localparam int unsigned PEN_STEP        = 6;
  localparam int unsigned MASK_BITS       = GLYPH_COLS * GLYPH_ROWS;

  localparam logic [15:0] COLOR_RESET = 16'hffff;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } gtor_state_t;

  // bit (col * GLYPH_ROWS + row) set means pixel drawn
  typedef logic [MASK_BITS-1:0] glyph_mask_t;

  typedef struct packed {
    glyph_mask_t mask;
    logic [8:0]  x_start;   // mirrored x of column 0
  } scan_cmd_t;

  typedef logic [0:4][7:0] glyph_cols_t;

  function automatic glyph_cols_t font_cols(input logic [7:0] code);
    glyph_cols_t g;
    unique case (code)
      8'h30: g = 40'h3e5149453e;
      8'h31: g = 40'h00427f4000;
      8'h32: g = 40'h4261514946;
      8'h33: g = 40'h2141454b31;
      8'h34: g = 40'h1814127f10;
      8'h35: g = 40'h2745454539;
      8'h36: g = 40'h3c4a494930;
      8'h37: g = 40'h0171090503;
      8'h38: g = 40'h3649494936;
      8'h39: g = 40'h064949291e;
      8'h41: g = 40'h7e1111117e;
      8'h42: g = 40'h7f49494936;
      8'h43: g = 40'h3e41414122;
      8'h44: g = 40'h7f4141221c;
      8'h45: g = 40'h7f49494941;
      8'h46: g = 40'h7f09090901;
      8'h47: g = 40'h3e4149497a;
      8'h48: g = 40'h7f0808087f;
      8'h49: g = 40'h00417f4100;
      8'h4a: g = 40'h2040413f01;
      8'h4b: g = 40'h7f08142241;
      8'h4c: g = 40'h7f40404040;
      8'h4d: g = 40'h7f020c027f;
      8'h4e: g = 40'h7f0408107f;
      8'h4f: g = 40'h3e4141413e;
      8'h50: g = 40'h7f09090906;
      8'h51: g = 40'h3e4151215e;
      8'h52: g = 40'h7f09192946;
      8'h53: g = 40'h4649494931;
      8'h54: g = 40'h01017f0101;
      8'h55: g = 40'h3f4040403f;
      8'h56: g = 40'h1f2040201f;
      8'h57: g = 40'h3f4038403f;
      8'h58: g = 40'h6314081463;
      8'h59: g = 40'h0708700807;
      8'h5a: g = 40'h6151494543;
      8'h3a: g = 40'h0036360000;
      8'h2e: g = 40'h0060600000;
      8'h2c: g = 40'h0080600000;
      8'h25: g = 40'h6313086463;
      8'h2d: g = 40'h0808080808;
      8'h2f: g = 40'h2010080402;
      default: g = '0;
    endcase
    return g;
  endfunction

  // bit 7 of each column byte is dropped here
  function automatic glyph_mask_t glyph_mask(input logic [7:0] code);
    glyph_cols_t g;
    glyph_mask_t m;
    g = font_cols(code);
    m = '0;
    for (int c = 0; c < GLYPH_COLS; c++) begin
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        m[c*GLYPH_ROWS + r] = g[c][r];
      end
    end
    return m;
  endfunction

endpackage

[design/gtor_if.sv]
interface gtor_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       line_start;

  modport source (output valid, char_code, line_start, input ready);
  modport sink   (input valid, char_code, line_start, output ready);
endinterface

interface gtor_pix_if;
  logic        valid;
  logic        ready;
  logic [8:0]  mirrored_x;
  logic [2:0]  pixel_row;
  logic [12:0] byte_offset;
  logic [15:0] pixel_color;
  logic        last_write;

  modport source (output valid, mirrored_x, pixel_row, byte_offset, pixel_color,
                  last_write, input ready);
  modport sink   (input valid, mirrored_x, pixel_row, byte_offset, pixel_color,
                  last_write, output ready);
endinterface

[design/glyph_text_overlay_renderer.sv]
// 5x7 character generator for a text overlay.
// in_chan: one character per beat (char_code, line_start). line_start puts
// the pen back to column 1 before the character is placed.
// out_chan: one pixel write per set glyph bit, column by column, rows 0..6,
// carrying mirrored x, row, byte offset and the text color; last_write
// marks the final beat of a character.
// cfg_we/cfg_wdata: writes text_color (reset 0xffff); write only when idle.
// A character whose pen position fails pen + 5 < frame width is clipped:
// no beats, pen unchanged. Blank and unknown codes give no beats but move
// the pen by 6.
// Timing: the scanner walks one glyph bit per cycle up to the last set bit,
// so an item holds in_chan.ready low while its mask is scanned and until
// the scanner returns to idle. The first beat is registered once the mask
// is loaded and the scan reaches the first set bit, later for each clear
// bit ahead of it. A clipped item never starts the scanner. The result
// register lets the next item be accepted while the last beat still
// waits; a stall on out_chan freezes the scan. Reset (rst_n low, sync)
// sets pen to 1, color to white and drops all pending beats.
module glyph_text_overlay_renderer
  import gtor_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  gtor_char_if.sink   in_chan,
  gtor_pix_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [8:0]  pen_r;
  logic [15:0] color_r;
  logic [8:0]  pen_eff;
  logic        clip;
  logic        accept;
  logic        start;
  logic        busy;
  scan_cmd_t   cmd;

  assign pen_eff = in_chan.line_start ? 9'd1 : pen_r;
  assign clip    = ({1'b0, pen_eff} + 10'(GLYPH_COLS)) >= 10'(FRAME_WIDTH);
  assign accept  = in_chan.valid && in_chan.ready;
  assign start   = accept && !clip;

  assign cmd.mask    = glyph_mask(in_chan.char_code);
  assign cmd.x_start = 9'(FRAME_WIDTH - 1) - pen_eff;

  assign in_chan.ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r <= 9'd1;
    end else if (accept) begin
      pen_r <= clip ? pen_eff : pen_eff + 9'(PEN_STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= COLOR_RESET;
    end else if (cfg_we) begin
      color_r <= cfg_wdata;
    end
  end

  gtor_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .cmd        (cmd),
    .text_color (color_r),
    .busy       (busy),
    .out_chan   (out_chan)
  );

endmodule

[design/gtor_scan.sv]
`include "assert_macros.svh"

module gtor_scan
  import gtor_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  scan_cmd_t         cmd,
  input  logic [15:0]       text_color,
  output logic              busy,
  gtor_pix_if.source        out_chan
);

  gtor_state_t state_r, state_nxt;
  glyph_mask_t mask_r;
  logic [2:0]  row_r;
  logic [8:0]  x_r;
  logic        advance;

  logic        out_valid_r;
  logic [8:0]  out_x_r;
  logic [2:0]  out_row_r;
  logic [12:0] out_off_r;
  logic [15:0] out_color_r;
  logic        out_last_r;

  logic [15:0] off_full;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_SCAN;
      ST_SCAN: if (mask_r == '0) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = (state_r == ST_SCAN);
    advance = (state_r == ST_SCAN) && (mask_r != '0) && (!out_valid_r || out_chan.ready);
  end

  assign off_full = (16'(row_r) * 16'(FRAME_WIDTH) + 16'(x_r)) * 16'(BYTES_PER_PIXEL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // one mask bit per cycle while out_chan does not stall, column by column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (start && (state_r == ST_IDLE)) begin
      mask_r <= cmd.mask;
    end else if (advance) begin
      mask_r <= mask_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (start && (state_r == ST_IDLE)) begin
      row_r <= '0;
      x_r   <= cmd.x_start;
    end else if (advance) begin
      if (row_r == 3'(GLYPH_ROWS - 1)) begin
        row_r <= '0;
        x_r   <= x_r - 9'd1;
      end else begin
        row_r <= row_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && mask_r[0]) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && mask_r[0]) begin
      out_x_r     <= x_r;
      out_row_r   <= row_r;
      out_off_r   <= off_full[12:0];
      out_color_r <= text_color;
      out_last_r  <= (mask_r[MASK_BITS-1:1] == '0);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.mirrored_x  = out_x_r;
  assign out_chan.pixel_row   = out_row_r;
  assign out_chan.byte_offset = out_off_r;
  assign out_chan.pixel_color = out_color_r;
  assign out_chan.last_write  = out_last_r;

  `ASSERT_NEVER(a_start_busy, clk, rst_n, start && busy)
  `ASSERT_CLK(a_empty_done, clk, rst_n, (busy && mask_r == '0) |=> !busy)
  `ASSERT_CLK(a_mid_beat_busy, clk, rst_n, (out_valid_r && !out_last_r) |-> busy)
  `ASSERT_NEVER(a_row_range, clk, rst_n, busy && (row_r > 3'(GLYPH_ROWS - 1)))

endmodule

[tb/glyph_overlay_pixel_monitor.sv]
`timescale 1ns / 100ps

module glyph_overlay_pixel_monitor
  import gtor_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  gtor_char_if        char_mon,
  gtor_pix_if         pix_mon,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending_writes,
  output int          chars_taken,
  output int          chars_clipped,
  output int          writes_checked
);

  typedef struct packed {
    logic [8:0]  x;
    logic [2:0]  row;
    logic [12:0] offset;
    logic [15:0] color;
    logic        last;
  } pixel_write_t;

  // column bytes, bit n = row n
  localparam logic [0:9][0:4][7:0] DIGIT_COLS = {
    40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31, 40'h1814127f10,
    40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936, 40'h064949291e
  };

  localparam logic [0:25][0:4][7:0] LETTER_COLS = {
    40'h7e1111117e, 40'h7f49494936, 40'h3e41414122, 40'h7f4141221c, 40'h7f49494941,
    40'h7f09090901, 40'h3e4149497a, 40'h7f0808087f, 40'h00417f4100, 40'h2040413f01,
    40'h7f08142241, 40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
    40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931, 40'h01017f0101,
    40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f, 40'h6314081463, 40'h0708700807,
    40'h6151494543
  };

  // order: colon, period, comma, percent, minus, slash
  localparam logic [0:5][0:4][7:0] MARK_COLS = {
    40'h0036360000, 40'h0060600000, 40'h0080600000, 40'h6313086463, 40'h0808080808,
    40'h2010080402
  };

  logic [8:0]   pen;
  logic [15:0]  text_color;
  pixel_write_t expected_writes[$];
  int           n_fail = 0;
  int           n_chars = 0;
  int           n_clip = 0;
  int           n_writes = 0;

  function automatic logic [7:0] column_byte(input logic [7:0] code, input int col);
    if (code >= "0" && code <= "9") return DIGIT_COLS[code - "0"][col];
    if (code >= "A" && code <= "Z") return LETTER_COLS[code - "A"][col];
    case (code)
      ":": return MARK_COLS[0][col];
      ".": return MARK_COLS[1][col];
      ",": return MARK_COLS[2][col];
      "%": return MARK_COLS[3][col];
      "-": return MARK_COLS[4][col];
      "/": return MARK_COLS[5][col];
      default: return 8'h00;
    endcase
  endfunction

  task automatic predict_char_writes(input logic [7:0] code, input logic line_start);
    pixel_write_t held;
    bit           have_held;
    logic [7:0]   bits;
    int           mx;
    if (line_start) pen = 9'd1;
    if (pen + GLYPH_COLS >= FRAME_WIDTH) begin
      // clipped: pen stays put
      n_clip++;
      return;
    end
    have_held = 1'b0;
    for (int c = 0; c < GLYPH_COLS; c++) begin
      bits = column_byte(code, c);
      // bit 7 is outside the 7-row scan
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        if (bits[r]) begin
          if (have_held) expected_writes.push_back(held);
          mx = int'(FRAME_WIDTH - 1 - (pen + c));
          held.x = 9'(mx);
          held.row = 3'(r);
          held.offset = 13'((r * FRAME_WIDTH + mx) * BYTES_PER_PIXEL);
          held.color = text_color;
          held.last = 1'b0;
          have_held = 1'b1;
        end
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      expected_writes.push_back(held);
    end
    pen = 9'(pen + PEN_STEP);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin : watch
    pixel_write_t want;
    if (!rst_n) begin
      pen = 9'd1;
      text_color = COLOR_RESET;
      expected_writes.delete();
    end else begin
      if (cfg_we) text_color = cfg_wdata;
      if (pix_mon.valid && pix_mon.ready) begin
        n_writes++;
        if (expected_writes.size() == 0) begin
          $error("unexpected pixel write: x %0d row %0d", pix_mon.mirrored_x,
                 pix_mon.pixel_row);
          n_fail++;
        end else begin
          want = expected_writes.pop_front();
          check_field("mirrored_x", int'(want.x), int'(pix_mon.mirrored_x));
          check_field("pixel_row", int'(want.row), int'(pix_mon.pixel_row));
          check_field("byte_offset", int'(want.offset), int'(pix_mon.byte_offset));
          check_field("pixel_color", int'(want.color), int'(pix_mon.pixel_color));
          check_field("last_write", int'(want.last), int'(pix_mon.last_write));
        end
      end
      if (char_mon.valid && char_mon.ready) begin
        n_chars++;
        predict_char_writes(char_mon.char_code, char_mon.line_start);
      end
    end
    fail_count     <= n_fail;
    pending_writes <= expected_writes.size();
    chars_taken    <= n_chars;
    chars_clipped  <= n_clip;
    writes_checked <= n_writes;
  end

endmodule

[tb/glyph_text_overlay_renderer_test.sv]
`timescale 1ns / 100ps

module glyph_text_overlay_renderer_test;
  import gtor_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 70;
  localparam int IDLE_PCT      = 8;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  bit          steady = 1'b0;
  bit          hold_pending = 1'b0;
  int          colors_used = 0;
  int          fail_count;
  int          pending_writes;
  int          chars_taken;
  int          chars_clipped;
  int          writes_checked;
  string       glyph_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ:.,%-/";

  gtor_char_if char_bus ();
  gtor_pix_if  pix_bus ();

  glyph_text_overlay_renderer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (char_bus),
    .out_chan  (pix_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  glyph_overlay_pixel_monitor u_pixel_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .char_mon       (char_bus),
    .pix_mon        (pix_bus),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .pending_writes (pending_writes),
    .chars_taken    (chars_taken),
    .chars_clipped  (chars_clipped),
    .writes_checked (writes_checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin : watchdog
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // pixel side: random back-pressure, plus one long hold-off on request
  initial begin : pixel_sink
    pix_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        pix_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pix_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic push_char(input logic [7:0] code, input logic line_start);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      char_bus.valid <= 1'b0;
      @(posedge clk);
    end
    char_bus.valid      <= 1'b1;
    char_bus.char_code  <= code;
    char_bus.line_start <= line_start;
    @(posedge clk);
    while (!char_bus.ready) @(posedge clk);
  endtask

  // the scanner can still be busy on a blank glyph after the last beat
  task automatic drain();
    char_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_writes != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_color(input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    colors_used++;
  endtask

  // mostly lines of real glyphs; the first line of each batch runs past the
  // right edge so clipping is always reached
  task automatic send_random(input int n_items);
    int         sent;
    int         line_len;
    logic [7:0] code;
    logic       line_start;
    sent = 0;
    while (sent < n_items) begin
      if (sent == 0 || $urandom_range(3) == 0) line_len = $urandom_range(56, 64);
      else line_len = $urandom_range(1, 12);
      for (int i = 0; i < line_len && sent < n_items; i++) begin
        if ($urandom_range(99) < 15) code = 8'($urandom_range(255));
        else code = glyph_set[$urandom_range(glyph_set.len() - 1)];
        line_start = (i == 0) || (line_len < 20 && $urandom_range(99) < 5);
        push_char(code, line_start);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= 16'h0000;
    char_bus.valid      <= 1'b0;
    char_bus.char_code  <= 8'h00;
    char_bus.line_start <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_color(16'h0000);
    push_char("A", 1'b1);
    push_char("0", 1'b0);
    push_char("9", 1'b0);
    push_char("Z", 1'b0);
    push_char("M", 1'b0);
    push_char(":", 1'b0);
    push_char(".", 1'b0);
    push_char(",", 1'b0);   // top bit of a column set, never drawn
    push_char("%", 1'b0);
    push_char("-", 1'b0);
    push_char("/", 1'b0);
    push_char(" ", 1'b0);
    push_char(8'h00, 1'b0);
    push_char(8'hff, 1'b0);
    push_char("a", 1'b0);
    push_char(8'h7f, 1'b0);
    push_char("8", 1'b0);
    push_char("I", 1'b1);
    push_char("W", 1'b0);
    push_char("Q", 1'b0);
    push_char("G", 1'b1);
    drain();

    write_color(16'hffff);
    send_random(PHASE_ITEMS);
    drain();

    // no idling here, and the pixel side stalls long enough to back up the input
    write_color(16'($urandom_range(16'hffff)));
    steady = 1'b1;
    hold_pending = 1'b1;
    send_random(PHASE_ITEMS);
    drain();
    steady = 1'b0;

    write_color(16'h8000);
    send_random(PHASE_ITEMS);
    drain();

    $display("Coverage: %0d characters (%0d clipped), %0d pixel writes, %0d colors.",
             chars_taken, chars_clipped, writes_checked, colors_used);
    if (fail_count == 0 && pending_writes == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
